// File: rtl/bslcd_pkg.sv
`timescale 1ns / 1ps

package bslcd_pkg;

   // counter widths
   localparam int HOLD_WIDTH  = 16;
   localparam int TIMER_WIDTH = 10;

   // register field widths
   localparam int DELAY_CFG_WIDTH = 10;
   localparam int LIMIT_CFG_WIDTH = 16;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHECK_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHORT_LIMIT  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_LIMIT   = 2'd3;

   // register reset values
   localparam logic [DELAY_CFG_WIDTH-1:0] DEBOUNCE_RESET     = 10'd20;
   localparam logic [DELAY_CFG_WIDTH-1:0] CHECK_PERIOD_RESET = 10'd100;
   localparam logic [LIMIT_CFG_WIDTH-1:0] SHORT_LIMIT_RESET  = 16'd500;
   localparam logic [LIMIT_CFG_WIDTH-1:0] LONG_LIMIT_RESET   = 16'd1000;

   localparam logic [HOLD_WIDTH-1:0]  HOLD_MAX  = {HOLD_WIDTH{1'b1}};
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      NO_CLICK    = 2'd0,
      CLICK_SHORT = 2'd1,
      CLICK_LONG  = 2'd2
   } click_type;

   typedef struct packed {
      logic [DELAY_CFG_WIDTH-1:0] debounce_ticks;
      logic [DELAY_CFG_WIDTH-1:0] check_period_ticks;
      logic [LIMIT_CFG_WIDTH-1:0] short_limit_ticks;
      logic [LIMIT_CFG_WIDTH-1:0] long_limit_ticks;
   } cfg_type;

   typedef struct packed {
      logic      pressed_now;
      click_type click_event;
   } result_type;

   // timer load value, saturated at the timer range
   function automatic logic [TIMER_WIDTH-1:0] timer_load(
      input logic [DELAY_CFG_WIDTH-1:0] value
   );
      logic [31:0] wide;
      wide = 32'(value);
      if (wide > 32'(TIMER_MAX)) begin
         return TIMER_MAX;
      end
      return TIMER_WIDTH'(wide);
   endfunction

endpackage

// File: rtl/bslcd_tick.sv
`timescale 1ns / 1ps

module bslcd_tick (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 pin_level,
   input  bslcd_pkg::cfg_type    cfg,
   output bslcd_pkg::result_type result
);
   import bslcd_pkg::*;

   logic                   prev_ff,    prev_in;
   logic                   armed_ff,   armed_in;
   logic [TIMER_WIDTH-1:0] count_ff,   count_in;
   logic                   pressed_ff, pressed_in;
   logic [HOLD_WIDTH-1:0]  hold_ff,    hold_in;
   logic                   long_ff,    long_in;

   always_comb begin
      logic [HOLD_WIDTH-1:0] hold_inc;
      click_type             ev;
      hold_inc = hold_ff;
      if (pressed_ff && (hold_ff != HOLD_MAX)) begin
         hold_inc = hold_ff + 1'b1;
      end
      prev_in    = prev_ff;
      armed_in   = armed_ff;
      count_in   = count_ff;
      pressed_in = pressed_ff;
      hold_in    = hold_inc;
      long_in    = long_ff;
      ev         = NO_CLICK;

      if (pin_level != prev_ff) begin
         // edge re-arms the debounce timer
         prev_in  = pin_level;
         armed_in = 1'b1;
         count_in = timer_load(cfg.debounce_ticks);
      end else if (armed_ff) begin
         if (count_ff <= TIMER_WIDTH'(1)) begin
            armed_in = 1'b0;
            count_in = '0;
            if (pin_level != pressed_ff) begin
               if (pin_level) begin
                  // new press
                  pressed_in = 1'b1;
                  hold_in    = '0;
                  long_in    = 1'b0;
                  armed_in   = 1'b1;
                  count_in   = timer_load(cfg.check_period_ticks);
               end else begin
                  // release
                  pressed_in = 1'b0;
                  if (!long_ff &&
                      (32'(hold_inc) < 32'(cfg.short_limit_ticks))) begin
                     ev = CLICK_SHORT;
                  end
               end
            end else if (pressed_ff && !long_ff) begin
               // periodic check while held
               if (32'(hold_inc) >= 32'(cfg.long_limit_ticks)) begin
                  long_in = 1'b1;
                  ev      = CLICK_LONG;
               end
               armed_in = 1'b1;
               count_in = timer_load(cfg.check_period_ticks);
            end
         end else begin
            count_in = count_ff - 1'b1;
         end
      end

      result.click_event = ev;
      result.pressed_now = pressed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= 1'b0;
         armed_ff   <= 1'b0;
         count_ff   <= '0;
         pressed_ff <= 1'b0;
         hold_ff    <= '0;
         long_ff    <= 1'b0;
      end else if (step) begin
         prev_ff    <= prev_in;
         armed_ff   <= armed_in;
         count_ff   <= count_in;
         pressed_ff <= pressed_in;
         hold_ff    <= hold_in;
         long_ff    <= long_in;
      end
   end

endmodule

// File: rtl/button_short_long_click_detector_core.sv
`timescale 1ns / 1ps
// an accepted req beat passes through the input register and then the result register to its rsp beat
// throughput: one tick per cycle while rsp_tready stays high; bslcd_tick updates its state once per tick
// a stalled rsp side holds one result and one more tick in the input register
// reset (synchronous, active high) clears the detector state and both stage valids,
// and loads the csr registers with 20, 100, 500 and 1000 ticks

module button_short_long_click_detector_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // tick input channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // [0] pin_level, [7:1] ignored
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,  // [1:0] click_event, [2] pressed_now
   // configuration writes
   input  logic                                  csr_we,
   input  logic [bslcd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bslcd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import bslcd_pkg::*;

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks     <= DEBOUNCE_RESET;
         cfg_ff.check_period_ticks <= CHECK_PERIOD_RESET;
         cfg_ff.short_limit_ticks  <= SHORT_LIMIT_RESET;
         cfg_ff.long_limit_ticks   <= LONG_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE:     cfg_ff.debounce_ticks     <= csr_wdata[DELAY_CFG_WIDTH-1:0];
            CSR_CHECK_PERIOD: cfg_ff.check_period_ticks <= csr_wdata[DELAY_CFG_WIDTH-1:0];
            CSR_SHORT_LIMIT:  cfg_ff.short_limit_ticks  <= csr_wdata[LIMIT_CFG_WIDTH-1:0];
            CSR_LONG_LIMIT:   cfg_ff.long_limit_ticks   <= csr_wdata[LIMIT_CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // input stage: one sampled tick waiting for the detector
   logic in_valid_ff;
   logic in_pin_ff;
   // result stage
   logic       out_valid_ff;
   result_type out_result_ff;
   result_type step_result;

   // the detector steps when the input stage moves into a free result register
   logic advance;
   assign advance = in_valid_ff && (!out_valid_ff || rsp_tready);

   // input stage frees up in the same cycle it hands its tick on
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_pin_ff <= req_tdata[0];
      end
   end

   // detector state and per-tick update
   bslcd_tick u_tick (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .pin_level (in_pin_ff),
      .cfg       (cfg_ff),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_result_ff.pressed_now, out_result_ff.click_event};

endmodule
